FILE: design/fckc_pkg.sv
package fckc_pkg;

  localparam int ENTRIES_DEFAULT = 256;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] key_hash;
    logic [23:0] key_len;
    logic [63:0] handle;
    logic [23:0] payload_size;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  slot;
    logic [63:0] hit_handle;
    logic [23:0] hit_size;
    logic        evicted;
    logic [63:0] evicted_handle;
    logic [23:0] evicted_size;
    logic [8:0]  occupancy;
  } rsp_t;

  typedef struct packed {
    logic [63:0] tag_hash;
    logic [23:0] tag_length;
    logic [63:0] entry_handle;
    logic [23:0] entry_size;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

FILE: design/fckc_cell.sv
module fckc_cell import fckc_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    nbr,
  input  entry_t    ld,
  output entry_t    q
);

  entry_t data;

  // a load wins over the shift from the younger neighbor
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= ld;
    end else if (ctl.shift) begin
      data <= nbr;
    end
  end

  assign q = data;

endmodule

FILE: design/fifo_compacting_keyed_cache_top.sv
// keyed lookup table kept in insertion order, oldest entry in cell 0
// command beat: req is taken at a clock edge with start high and busy low
// result beat: rsp is valid for exactly one cycle while done is high; the
// receiver cannot stall, so every result must be taken in that cycle
// insert, and any command that needs no search (zero handle, zero key
// length, empty table, unused code), gives done in the cycle after the
// command beat; the block is free again in that same cycle
// lookup and remove rotate the whole table once through the cell chain:
// the head cell is compared each cycle and then written back at the tail
// (or dropped, for the removed entry), and busy stays high from the command
// beat until done
// a full insert shifts every cell down by one and loads the new entry at
// the last cell in the same cycle
// reset empties the table (entry count to zero); cell contents are left
// as they were and are only read below the entry count
module fifo_compacting_keyed_cache_top import fckc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IW = $clog2(ENTRIES);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] steps, steps_next;
  logic [CW-1:0] step_idx, step_idx_next;
  req_t          op, op_next;
  rsp_t          res, res_next;
  logic          done_q, done_next;

  entry_t        ent [ENTRIES];
  entry_t        head;
  entry_t        ld_data;
  logic          shift_all;
  logic          ld_en;
  logic [IW-1:0] ld_idx;
  logic [CW-1:0] cnt_m1;
  logic          match;
  logic          first;
  logic          drop;

  assign head   = ent[0];
  assign cnt_m1 = count - CW'(1);

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      cell_ctl_t ctl;
      entry_t    nbr;
      assign ctl.shift = shift_all;
      assign ctl.load  = ld_en && (ld_idx == IW'(gi));
      if (gi == ENTRIES - 1) begin : g_last
        assign nbr = ld_data;
      end else begin : g_mid
        assign nbr = ent[gi+1];
      end
      fckc_cell u_cell (
        .clk (clk),
        .ctl (ctl),
        .nbr (nbr),
        .ld  (ld_data),
        .q   (ent[gi])
      );
    end
  endgenerate

  always_comb begin
    state_next    = state;
    count_next    = count;
    steps_next    = steps;
    step_idx_next = step_idx;
    op_next       = op;
    res_next      = res;
    done_next     = 1'b0;
    shift_all     = 1'b0;
    ld_en         = 1'b0;
    ld_idx        = cnt_m1[IW-1:0];
    ld_data       = head;
    match         = 1'b0;
    first         = 1'b0;
    drop          = 1'b0;

    case (state)
      S_IDLE: begin
        if (start) begin
          res_next           = '0;
          res_next.occupancy = 9'(count);
          op_next            = req;
          steps_next         = count;
          step_idx_next      = '0;
          case (req.cmd)
            CMD_LOOKUP: begin
              if (req.key_len == '0 || count == '0) begin
                done_next = 1'b1;
              end else begin
                state_next = S_SCAN;
              end
            end
            CMD_INSERT: begin
              done_next = 1'b1;
              if (req.handle != '0) begin
                ld_en                = 1'b1;
                ld_data.tag_hash     = req.key_hash;
                ld_data.tag_length   = req.key_len;
                ld_data.entry_handle = req.handle;
                ld_data.entry_size   = req.payload_size;
                if (count == CW'(ENTRIES)) begin
                  // full: oldest entry falls out of cell 0
                  shift_all               = 1'b1;
                  ld_idx                  = IW'(ENTRIES - 1);
                  res_next.evicted        = 1'b1;
                  res_next.evicted_handle = head.entry_handle;
                  res_next.evicted_size   = head.entry_size;
                  res_next.slot           = 8'(ENTRIES - 1);
                end else begin
                  ld_idx             = count[IW-1:0];
                  count_next         = count + CW'(1);
                  res_next.slot      = 8'(count);
                  res_next.occupancy = 9'(count + CW'(1));
                end
              end
            end
            CMD_REMOVE: begin
              if (req.handle == '0 || count == '0) begin
                done_next = 1'b1;
              end else begin
                state_next = S_SCAN;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (op.cmd == CMD_LOOKUP) begin
          match = (head.tag_hash == op.key_hash) && (head.tag_length == op.key_len);
        end else begin
          match = (head.entry_handle == op.handle);
        end
        first = match && !res.found;
        drop  = first && (op.cmd == CMD_REMOVE);
        // head goes back in at the tail unless it is the removed entry
        shift_all = 1'b1;
        ld_en     = !drop;
        if (drop) begin
          count_next = cnt_m1;
        end
        if (first) begin
          res_next.found      = 1'b1;
          res_next.slot       = 8'(step_idx);
          res_next.hit_handle = head.entry_handle;
          res_next.hit_size   = head.entry_size;
        end
        step_idx_next = step_idx + CW'(1);
        if (step_idx == steps - CW'(1)) begin
          state_next         = S_IDLE;
          done_next          = 1'b1;
          res_next.occupancy = 9'(count_next);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      done_q <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      done_q <= done_next;
    end
    steps    <= steps_next;
    step_idx <= step_idx_next;
    op       <= op_next;
    res      <= res_next;
  end

  assign busy = (state != S_IDLE);
  assign done = done_q;
  assign rsp  = res;

endmodule

FILE: tb/sv/tb_fifo_compacting_keyed_cache_top.sv
module tb_fifo_compacting_keyed_cache_top;
  import fckc_pkg::*;

  localparam int ENTRIES = ENTRIES_DEFAULT;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RAND_ITEMS = 1930;
  localparam int PHASE_LEN = 650;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    req_t req;
    bit   fixed;
    rsp_t rsp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  // shadow of the table, oldest entry at index 0
  entry_t cache_tbl [ENTRIES];
  int     tbl_count = 0;
  rsp_t   rsp_due_q [$];
  int     mismatches = 0;
  int     burst_left = 0;
  stim_row_t dir_rows [19];

  fifo_compacting_keyed_cache_top #(.ENTRIES(ENTRIES)) uut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  always #5 clk = ~clk;

  function automatic rsp_t cache_apply(input req_t r);
    rsp_t o;
    int   idx;
    int   i;
    o = '0;
    idx = -1;
    case (r.cmd)
      CMD_LOOKUP: begin
        if (r.key_len != '0) begin
          for (i = 0; i < tbl_count; i++) begin
            if (idx < 0 && cache_tbl[i].tag_hash == r.key_hash &&
                cache_tbl[i].tag_length == r.key_len) idx = i;
          end
        end
        if (idx >= 0) begin
          o.found = 1'b1;
          o.slot = 8'(idx);
          o.hit_handle = cache_tbl[idx].entry_handle;
          o.hit_size = cache_tbl[idx].entry_size;
        end
      end
      CMD_INSERT: begin
        if (r.handle != '0) begin
          if (tbl_count >= ENTRIES) begin
            o.evicted = 1'b1;
            o.evicted_handle = cache_tbl[0].entry_handle;
            o.evicted_size = cache_tbl[0].entry_size;
            for (i = 0; i + 1 < tbl_count; i++) cache_tbl[i] = cache_tbl[i + 1];
            tbl_count--;
          end
          cache_tbl[tbl_count] = '{r.key_hash, r.key_len, r.handle, r.payload_size};
          o.slot = 8'(tbl_count);
          tbl_count++;
        end
      end
      CMD_REMOVE: begin
        if (r.handle != '0) begin
          for (i = 0; i < tbl_count; i++) begin
            if (idx < 0 && cache_tbl[i].entry_handle == r.handle) idx = i;
          end
        end
        if (idx >= 0) begin
          o.found = 1'b1;
          o.slot = 8'(idx);
          o.hit_handle = cache_tbl[idx].entry_handle;
          o.hit_size = cache_tbl[idx].entry_size;
          for (i = idx; i + 1 < tbl_count; i++) cache_tbl[i] = cache_tbl[i + 1];
          tbl_count--;
        end
      end
      default: ;
    endcase
    o.occupancy = 9'(tbl_count);
    return o;
  endfunction

  // drive one command beat; start stays high across back-to-back beats
  task automatic issue(input req_t r, input bit fixed, input rsp_t fixed_rsp);
    int   gap;
    int   roll;
    rsp_t pred;
    roll = $urandom_range(99);
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else if (roll < 2) begin
      gap = 0;
      burst_left = $urandom_range(60, 20);
    end else if (roll < 50) gap = 0;
    else if (roll < 88) gap = $urandom_range(3, 1);
    else if (roll < 98) gap = $urandom_range(20, 4);
    else gap = $urandom_range(80, 30);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = cache_apply(r);
    rsp_due_q.push_back(fixed ? fixed_rsp : pred);
  endtask

  task automatic cmp_field(input string nm, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, nm, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (rsp_due_q.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $time, rsp);
        mismatches++;
      end else begin
        want = rsp_due_q.pop_front();
        cmp_field("found", 64'(want.found), 64'(rsp.found));
        cmp_field("slot", 64'(want.slot), 64'(rsp.slot));
        cmp_field("hit_handle", want.hit_handle, rsp.hit_handle);
        cmp_field("hit_size", 64'(want.hit_size), 64'(rsp.hit_size));
        cmp_field("evicted", 64'(want.evicted), 64'(rsp.evicted));
        cmp_field("evicted_handle", want.evicted_handle, rsp.evicted_handle);
        cmp_field("evicted_size", 64'(want.evicted_size), 64'(rsp.evicted_size));
        cmp_field("occupancy", 64'(want.occupancy), 64'(rsp.occupancy));
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    req_t r;
    int   n;
    int   phase;
    int   roll;
    int   sub;
    int   pick;
    int   ins_w;
    int   lk_w;
    int   rm_w;

    dir_rows = '{
      // empty table: everything misses
      '{'{CMD_LOOKUP, 64'd0, 24'd1, 64'd0, 24'd0}, 1'b1, '0},
      '{'{CMD_REMOVE, 64'd0, 24'd0, 64'd5, 24'd0}, 1'b1, '0},
      '{'{CMD_UNUSED, '1, '1, '1, '1}, 1'b1, '0},
      '{'{CMD_INSERT, '1, '1, 64'd0, '1}, 1'b1, '0},
      // all-ones entry
      '{'{CMD_INSERT, '1, '1, '1, '1}, 1'b1, '{1'b0, 8'd0, 64'd0, 24'd0, 1'b0, 64'd0, 24'd0, 9'd1}},
      '{'{CMD_LOOKUP, '1, '1, 64'd0, 24'd0}, 1'b1,
        '{1'b1, 8'd0, '1, 24'hFFFFFF, 1'b0, 64'd0, 24'd0, 9'd1}},
      '{'{CMD_INSERT, 64'd0, 24'd0, 64'd1, 24'd0}, 1'b1,
        '{1'b0, 8'd1, 64'd0, 24'd0, 1'b0, 64'd0, 24'd0, 9'd2}},
      // zero key length never hits, even on a stored zero-length key
      '{'{CMD_LOOKUP, 64'd0, 24'd0, 64'd0, 24'd0}, 1'b1,
        '{1'b0, 8'd0, 64'd0, 24'd0, 1'b0, 64'd0, 24'd0, 9'd2}},
      '{'{CMD_INSERT, 64'd0, 24'd1, 64'd2, 24'd7}, 1'b0, '0},
      // duplicate key, lookup must return the older one
      '{'{CMD_INSERT, 64'd0, 24'd1, 64'd3, 24'd9}, 1'b0, '0},
      '{'{CMD_LOOKUP, 64'd0, 24'd1, 64'd0, 24'd0}, 1'b0, '0},
      '{'{CMD_LOOKUP, '1, 24'hFFFFFE, 64'd0, 24'd0}, 1'b0, '0},
      '{'{CMD_REMOVE, 64'd0, 24'd0, 64'd2, 24'd0}, 1'b0, '0},
      '{'{CMD_LOOKUP, 64'd0, 24'd1, 64'd0, 24'd0}, 1'b0, '0},
      '{'{CMD_REMOVE, '1, '1, 64'd0, '1}, 1'b1,
        '{1'b0, 8'd0, 64'd0, 24'd0, 1'b0, 64'd0, 24'd0, 9'd3}},
      '{'{CMD_REMOVE, 64'd0, 24'd0, 64'h1234, 24'd0}, 1'b0, '0},
      '{'{CMD_REMOVE, 64'd0, 24'd0, '1, 24'd0}, 1'b0, '0},
      '{'{CMD_LOOKUP, '1, '1, 64'd0, 24'd0}, 1'b0, '0},
      '{'{CMD_UNUSED, 64'd0, 24'd0, 64'd0, 24'd0}, 1'b0, '0}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) issue(dir_rows[k].req, dir_rows[k].fixed, dir_rows[k].rsp);

    // fill to eviction, drain to empty, then a balanced mix
    for (n = 0; n < RAND_ITEMS; n++) begin
      phase = n / PHASE_LEN;
      case (phase)
        0: begin ins_w = 55; lk_w = 30; rm_w = 10; end
        1: begin ins_w = 10; lk_w = 25; rm_w = 60; end
        default: begin ins_w = 40; lk_w = 35; rm_w = 20; end
      endcase
      roll = $urandom_range(99);
      sub = $urandom_range(19);
      pick = (tbl_count > 0) ? $urandom_range(tbl_count - 1) : 0;
      r.key_hash = {$urandom, $urandom};
      r.key_len = 24'($urandom);
      r.handle = {$urandom, $urandom};
      r.payload_size = 24'($urandom);
      if (r.handle == '0) r.handle = 64'd1;
      if (roll < ins_w) begin
        r.cmd = CMD_INSERT;
        if (sub == 0) r.handle = '0;
        else if (sub < 4 && tbl_count > 0) begin
          r.key_hash = cache_tbl[pick].tag_hash;
          r.key_len = cache_tbl[pick].tag_length;
        end else if (sub == 4 && tbl_count > 0) r.handle = cache_tbl[pick].entry_handle;
        else if (sub == 5) r.key_len = '0;
      end else if (roll < ins_w + lk_w) begin
        r.cmd = CMD_LOOKUP;
        if (sub < 13 && tbl_count > 0) begin
          r.key_hash = cache_tbl[pick].tag_hash;
          r.key_len = cache_tbl[pick].tag_length;
        end else if (sub < 15 && tbl_count > 0) begin
          // right hash, length off by one bit
          r.key_hash = cache_tbl[pick].tag_hash;
          r.key_len = cache_tbl[pick].tag_length ^ 24'(1 << $urandom_range(23));
        end else if (sub == 15) r.key_len = '0;
      end else if (roll < ins_w + lk_w + rm_w) begin
        r.cmd = CMD_REMOVE;
        if (sub < 14 && tbl_count > 0) r.handle = cache_tbl[pick].entry_handle;
        else if (sub == 14) r.handle = '0;
      end else begin
        r.cmd = CMD_UNUSED;
      end
      issue(r, 1'b0, '0);
    end
    start <= 1'b0;

    while (rsp_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
